>>> hw/rtl/bsg_pkg.sv
// ----------------------------------------------------------------------------
// Bounding sphere grow package
// Shared widths and types for the running bounding sphere block.
// ----------------------------------------------------------------------------
package bsg_pkg;

    localparam int CoordW  = 32;
    localparam int RadW    = 31;
    localparam int DiffW   = 33;
    localparam int ProdW   = 2 * DiffW;
    localparam int SumW    = 68;
    localparam int RootW   = 35;
    localparam int SremW   = 38;
    localparam int MoveW   = 34;
    localparam int DivW    = ProdW + 1;
    localparam int QuoW    = 36;
    localparam int NewW    = 40;

    localparam logic [RadW-1:0] RadMax = {RadW{1'b1}};

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [DiffW-1:0]  diff_t;

endpackage

>>> hw/rtl/bounding_sphere_grow.sv
// ----------------------------------------------------------------------------
// Bounding sphere grow
// Keeps a running bounding sphere in Q16.16 and grows it by one sphere or
// point per request, using one shared multiplier and bit-serial root and
// divide steps under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)               | tuser
//  s_axis   | in        | item_x, item_y, item_z, radius   | restart
//  m_axis   | out       | center_x, center_y, center_z,    | grew, saturated
//           |           | bound_radius                     |
// A request that restarts or fills an empty sphere goes straight to the
// output register. Any other request runs three square steps and 34 root
// steps and then finishes for coincident centers or an enclosed item. One
// that moves the sphere adds three axis passes, each running a 67-step divide.
// Reset empties the sphere. The input is not ready while a request is in work,
// and a finished result waits in the output register until it is taken.
module bounding_sphere_grow
    import bsg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // item_x, item_y, item_z, item_radius, zero pad
    input  logic         s_tuser,   // restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // center_x, center_y, center_z, bound_radius, pad
    output logic [1:0]   m_tuser    // grew, saturated
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_ROOT, ST_TEST, ST_CMP, ST_MV_MUL, ST_MV_HI,
        ST_DIV, ST_APPLY, ST_OUT
    } state_t;

    state_t                state_reg;
    coord_t                c_reg [3];
    logic [RadW-1:0]       rad_reg;
    logic                  empty_reg;
    diff_t                 d_reg [3];
    logic [RadW-1:0]       irad_reg;
    logic [1:0]            axis_reg;
    logic [ProdW-1:0]      prod_reg;
    logic [SumW-1:0]       sum_reg;
    logic [SumW-1:0]       sh_reg;
    logic [SremW-1:0]      srem_reg;
    logic [RootW-1:0]      root_reg;
    logic [RootW-1:0]      dist_reg;
    logic [MoveW-1:0]      move_reg;
    logic [DivW-1:0]       div_reg;
    logic [RootW-1:0]      rem_reg;
    logic [QuoW-1:0]       quo_reg;
    logic [6:0]            cnt_reg;
    logic                  grew_reg;
    logic                  sat_reg;
    logic                  ovalid_reg;
    logic [127:0]          odata_reg;
    logic [1:0]            ouser_reg;

    diff_t                 d_sel;
    logic [DiffW-1:0]      mag_sel;
    logic [DiffW-1:0]      op_b;
    logic [ProdW-1:0]      prod_next;
    logic [SremW-1:0]      srem_sh;
    logic [SremW-1:0]      trial;
    logic [RootW:0]        sum_dr;
    logic [RootW+1:0]      over;
    logic [RootW:0]        new_rad;
    logic [RootW:0]        rem_sh;
    logic [QuoW-1:0]       quo_rnd;
    logic signed [NewW-1:0] new_c;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    assign d_sel     = d_reg[axis_reg];
    assign mag_sel   = d_sel[DiffW-1] ? DiffW'(-d_sel) : DiffW'(d_sel);
    assign op_b      = (state_reg == ST_SQ_MUL) ? mag_sel : move_reg[DiffW-1:0];
    assign prod_next = ProdW'(mag_sel * op_b);
    assign srem_sh   = {srem_reg[SremW-3:0], sh_reg[SumW-1 -: 2]};
    assign trial     = SremW'({root_reg, 2'b01});
    assign sum_dr    = (RootW+1)'(dist_reg) + (RootW+1)'(irad_reg);
    assign over      = (RootW+2)'(sum_dr) - (RootW+2)'(rad_reg) + (RootW+2)'(1);
    assign new_rad   = (RootW+1)'(rad_reg) + (RootW+1)'(move_reg);
    assign rem_sh    = {rem_reg, div_reg[DivW-1]};
    assign quo_rnd   = ({1'b0, rem_reg} << 1) >= (RootW+1)'(dist_reg) ? quo_reg + 1'b1
                                                                     : quo_reg;
    assign new_c     = d_sel[DiffW-1]
                       ? NewW'(c_reg[axis_reg]) - NewW'(quo_rnd)
                       : NewW'(c_reg[axis_reg]) + NewW'(quo_rnd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            empty_reg  <= 1'b1;
            rad_reg    <= '0;
            c_reg[0]   <= '0;
            c_reg[1]   <= '0;
            c_reg[2]   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && m_tready && state_reg != ST_OUT)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        irad_reg <= s_tdata[96 +: RadW];
                        sat_reg  <= 1'b0;
                        axis_reg <= '0;
                        sum_reg  <= '0;
                        if (s_tuser || empty_reg)
                        begin
                            c_reg[0]  <= s_tdata[31:0];
                            c_reg[1]  <= s_tdata[63:32];
                            c_reg[2]  <= s_tdata[95:64];
                            rad_reg   <= s_tdata[96 +: RadW];
                            empty_reg <= 1'b0;
                            grew_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            grew_reg  <= 1'b0;
                            d_reg[0]  <= DiffW'(signed'(s_tdata[31:0])) - DiffW'(c_reg[0]);
                            d_reg[1]  <= DiffW'(signed'(s_tdata[63:32])) - DiffW'(c_reg[1]);
                            d_reg[2]  <= DiffW'(signed'(s_tdata[95:64])) - DiffW'(c_reg[2]);
                            state_reg <= ST_SQ_MUL;
                        end
                    end
                end
                ST_SQ_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    sum_reg <= sum_reg + SumW'(prod_reg);
                    if (axis_reg == 2'd2)
                    begin
                        sh_reg    <= sum_reg + SumW'(prod_reg);
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= 7'(SumW / 2 - 1);
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_ROOT:
                begin
                    sh_reg <= sh_reg << 2;
                    if (srem_sh >= trial)
                    begin
                        srem_reg <= srem_sh - trial;
                        root_reg <= {root_reg[RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= srem_sh;
                        root_reg <= {root_reg[RootW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST:
                begin
                    axis_reg <= '0;
                    if (sum_reg == '0)
                    begin
                        if (irad_reg > rad_reg)
                        begin
                            rad_reg  <= irad_reg;
                            grew_reg <= 1'b1;
                        end
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        dist_reg  <= root_reg + RootW'(srem_reg != '0);
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (sum_dr <= (RootW+1)'(rad_reg))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        move_reg  <= over[MoveW:1];
                        state_reg <= ST_MV_MUL;
                    end
                end
                ST_MV_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_MV_HI;
                end
                ST_MV_HI:
                begin
                    div_reg   <= DivW'(prod_reg)
                                 + (move_reg[MoveW-1] ? DivW'(mag_sel) << DiffW : '0);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= 7'(DivW - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_reg <= div_reg << 1;
                    if (rem_sh >= (RootW+1)'(dist_reg))
                    begin
                        rem_reg <= RootW'(rem_sh - (RootW+1)'(dist_reg));
                        quo_reg <= {quo_reg[QuoW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= RootW'(rem_sh);
                        quo_reg <= {quo_reg[QuoW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (new_c > NewW'(32'sh7FFFFFFF))
                    begin
                        c_reg[axis_reg] <= 32'sh7FFFFFFF;
                    end
                    else if (new_c < -NewW'(64'sh80000000))
                    begin
                        c_reg[axis_reg] <= 32'sh80000000;
                    end
                    else
                    begin
                        c_reg[axis_reg] <= new_c[CoordW-1:0];
                    end
                    if (axis_reg == 2'd2)
                    begin
                        grew_reg <= 1'b1;
                        if (new_rad > (RootW+1)'(RadMax))
                        begin
                            rad_reg <= RadMax;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            rad_reg <= new_rad[RadW-1:0];
                        end
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_MV_MUL;
                    end
                end
                ST_OUT:
                begin
                    if (!ovalid_reg || m_tready)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg  <= {1'b0, rad_reg, c_reg[2], c_reg[1], c_reg[0]};
                        ouser_reg  <= {sat_reg, grew_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
